@@ src/uvlt_pkg.sv @@
// ----------------------------------------------------------------------------
// uvlt_pkg
// Shared types and constants for the unsorted value list table.
// ----------------------------------------------------------------------------
package uvlt_pkg;

  localparam int unsigned DepthDef = 16;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned OpW      = 2;
  localparam int unsigned CountW   = 5;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic add;      // shift toward the back, cell 0 takes the new value
    logic clr;      // clear the match flags before a scan
    logic step;     // move the match flag one cell down the chain
    logic compact;  // cells at or past the first match take the next value
  } ctl_t;

endpackage

@@ src/uvlt_req_if.sv @@
// ----------------------------------------------------------------------------
// uvlt_req_if
// Request channel: operation code and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface uvlt_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic signed [31:0]  value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

@@ src/uvlt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// uvlt_rsp_if
// Response channel: status flags and entry count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface uvlt_rsp_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic        full_reject;
  logic [4:0]  entry_count;
  logic        is_empty;

  modport source (output valid, output success, output full_reject,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input success, input full_reject,
                  input entry_count, input is_empty, output ready);
endinterface

@@ src/uvlt_cell.sv @@
// ----------------------------------------------------------------------------
// uvlt_cell
// One list position: holds a value and a "match at or before here" flag.
// ----------------------------------------------------------------------------
module uvlt_cell #(
  parameter int unsigned Depth = uvlt_pkg::DepthDef,
  parameter int unsigned Idx   = 0,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  uvlt_pkg::ctl_t      ctl_i,
  input  logic [CntW-1:0]     count_i,
  input  logic signed [31:0]  key_i,
  input  logic signed [31:0]  prev_val_i,
  input  logic                prev_seen_i,
  input  logic signed [31:0]  next_val_i,
  output logic signed [31:0]  val_o,
  output logic                seen_o
);
  import uvlt_pkg::*;

  logic signed [31:0] val_q;
  logic               seen_q;
  logic               used;
  logic               hit;

  assign used = count_i > CntW'(Idx);
  assign hit  = used && (val_q == key_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.add) begin
      val_q <= prev_val_i;
    end else if (ctl_i.compact && seen_q) begin
      val_q <= next_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (ctl_i.clr) begin
      seen_q <= 1'b0;
    end else if (ctl_i.step) begin
      seen_q <= hit | prev_seen_i;
    end
  end

  assign val_o  = val_q;
  assign seen_o = seen_q;

endmodule

@@ src/unsorted_value_list_table.sv @@
// ----------------------------------------------------------------------------
// unsorted_value_list_table
// Value list, newest at the front, built as a chain of cells.
//
//   channel  dir  beat
//   req_i    in   op, value
//   rsp_o    out  success, full_reject, entry_count, is_empty
//
// Add and unused codes: the result is registered directly from the request beat.
// Search and remove: the match flag walks down the chain one cell per cycle,
// then the done state compacts the list on a remove hit and registers the result.
// Reset clears the entry count and flags only; cell values need no clearing.
// The result sits in an output register; a new request beat is taken in idle
// only, when that register is empty or drains in the same cycle.
// ----------------------------------------------------------------------------
module unsorted_value_list_table #(
  parameter int unsigned DEPTH = uvlt_pkg::DepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  uvlt_req_if.sink   req_i,
  uvlt_rsp_if.source rsp_o
);
  import uvlt_pkg::*;

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned ScanW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    count_q;
  logic [ScanW-1:0]   scan_q;
  logic               remove_q;
  logic signed [31:0] key_q;
  logic               out_valid_q;
  logic               success_q;
  logic               reject_q;
  logic [4:0]         entry_count_q;
  logic               is_empty_q;

  logic signed [31:0] vals  [DEPTH];
  logic               seens [DEPTH];

  ctl_t               ctl;
  logic               accept;
  logic               full;
  logic               found;
  logic [CntW-1:0]    count_d;
  logic [31:0]        count_ext;
  logic               success_d;
  logic               reject_d;
  op_e                op;

  assign op     = op_e'(req_i.op);
  assign full   = count_q == CntW'(DEPTH);
  assign found  = seens[DEPTH-1];
  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept = req_i.valid && req_i.ready;

  always_comb begin
    ctl         = '0;
    ctl.add     = accept && (op == OP_ADD) && !full;
    ctl.clr     = accept && ((op == OP_REMOVE) || (op == OP_SEARCH));
    ctl.step    = state_q == ST_SCAN;
    ctl.compact = (state_q == ST_DONE) && remove_q && found;
  end

  always_comb begin
    count_d   = count_q;
    success_d = 1'b0;
    reject_d  = 1'b0;
    if (state_q == ST_DONE) begin
      success_d = found;
      if (remove_q && found) begin
        count_d = count_q - CntW'(1);
      end
    end else if (accept && (op == OP_ADD)) begin
      if (full) begin
        reject_d = 1'b1;
      end else begin
        success_d = 1'b1;
        count_d   = count_q + CntW'(1);
      end
    end
  end

  assign count_ext = 32'(count_d);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] prev_val;
    logic               prev_seen;
    logic signed [31:0] next_val;

    if (i == 0) begin : g_head
      assign prev_val  = req_i.value;
      assign prev_seen = 1'b0;
    end else begin : g_body
      assign prev_val  = vals[i-1];
      assign prev_seen = seens[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_val = vals[i];
    end else begin : g_link
      assign next_val = vals[i+1];
    end

    uvlt_cell #(
      .Depth (DEPTH),
      .Idx   (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .count_i     (count_q),
      .key_i       (key_q),
      .prev_val_i  (prev_val),
      .prev_seen_i (prev_seen),
      .next_val_i  (next_val),
      .val_o       (vals[i]),
      .seen_o      (seens[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q    <= req_i.value;
      remove_q <= op == OP_REMOVE;
    end
    if ((state_q == ST_DONE) || (accept && !ctl.clr)) begin
      success_q     <= success_d;
      reject_q      <= reject_d;
      entry_count_q <= count_ext[4:0];
      is_empty_q    <= count_d == '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if ((state_q == ST_DONE) || (accept && !ctl.clr)) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && ctl.clr) begin
            state_q <= ST_SCAN;
            scan_q  <= '0;
          end
        end
        ST_SCAN: begin
          scan_q <= scan_q + ScanW'(1);
          if (scan_q == ScanW'(DEPTH - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.success     = success_q;
  assign rsp_o.full_reject = reject_q;
  assign rsp_o.entry_count = entry_count_q;
  assign rsp_o.is_empty    = is_empty_q;

endmodule

@@ test/unsorted_value_list_table_checker.sv @@
// ----------------------------------------------------------------------------
// unsorted_value_list_table_checker
// Watches the request and response channels of the value list. Keeps its own
// copy of the list, works out the status each request beat should produce,
// and compares every response beat with the oldest expected status.
// ----------------------------------------------------------------------------
module unsorted_value_list_table_checker
  import uvlt_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  uvlt_req_if         req_i,
  uvlt_rsp_if         rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic              success;
    logic              full_reject;
    logic [CountW-1:0] entry_count;
    logic              is_empty;
  } list_status_t;

  logic [ValueW-1:0] held_values [DEPTH];
  int unsigned       held_count;
  list_status_t      status_q [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [CountW-1:0] got,
                             input logic [CountW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  function automatic int find_value(input logic [ValueW-1:0] v);
    for (int i = 0; i < int'(held_count); i++) begin
      if (held_values[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic list_status_t apply_list_op(input logic [OpW-1:0] op,
                                                 input logic [ValueW-1:0] v);
    list_status_t st;
    int           pos;
    st = '0;
    case (op)
      OP_ADD: begin
        if (held_count >= DEPTH) begin
          st.full_reject = 1'b1;
        end else begin
          for (int i = int'(held_count); i > 0; i--) held_values[i] = held_values[i-1];
          held_values[0] = v;
          held_count++;
          st.success = 1'b1;
        end
      end
      OP_REMOVE: begin
        pos = find_value(v);
        if (pos >= 0) begin
          for (int i = pos; i + 1 < int'(held_count); i++) held_values[i] = held_values[i+1];
          held_count--;
          st.success = 1'b1;
        end
      end
      OP_SEARCH: begin
        st.success = (find_value(v) >= 0);
      end
      default: ;
    endcase
    st.entry_count = held_count[CountW-1:0];
    st.is_empty    = (held_count == 0);
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_status_t want;
    if (!rst_ni) begin
      status_q.delete();
      held_count   = 0;
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      // response first: it can only belong to an older request
      if (rsp_i.valid && rsp_i.ready) begin
        if (status_q.size() == 0) begin
          report_mismatch("response beat with no request outstanding");
        end else begin
          want = status_q.pop_front();
          check_field("success", CountW'(rsp_i.success), CountW'(want.success));
          check_field("full_reject", CountW'(rsp_i.full_reject),
                      CountW'(want.full_reject));
          check_field("entry_count", rsp_i.entry_count, want.entry_count);
          check_field("is_empty", CountW'(rsp_i.is_empty), CountW'(want.is_empty));
        end
      end
      if (req_i.valid && req_i.ready) begin
        status_q.push_back(apply_list_op(req_i.op, req_i.value));
      end
      pending_o = status_q.size();
    end
  end

endmodule

@@ test/unsorted_value_list_table_tb.sv @@
// ----------------------------------------------------------------------------
// unsorted_value_list_table_tb
// Drives add, remove, search and unused-code requests into the value list:
// a directed pass over empty, full, duplicate and extreme-value cases, then
// random traffic with a small value pool so lookups hit often. Both channels
// idle at random; the response side also holds off long enough to back up
// the block. The checker instance does the prediction and comparison.
// ----------------------------------------------------------------------------
module unsorted_value_list_table_tb;
  import uvlt_pkg::*;

  localparam logic [OpW-1:0] OpNop       = 2'd3;
  localparam int unsigned    RandItems   = 1500;
  localparam int unsigned    CalmItems   = 200;
  localparam int unsigned    PoolSize    = 6;
  localparam int unsigned    HoldAt      = 300;
  localparam int unsigned    HoldCycles  = 150;
  localparam int unsigned    DrainCycles = 2 * DepthDef + 8;
  localparam int unsigned    StallLimit  = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent_count;
  int unsigned quiet_cycles;
  bit          calm;

  uvlt_req_if req ();
  uvlt_rsp_if rsp ();

  unsorted_value_list_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  unsorted_value_list_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_request(input logic [OpW-1:0] op, input logic [ValueW-1:0] value);
    req.valid <= 1'b1;
    req.op    <= op;
    req.value <= value;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
    sent_count++;
  endtask

  task automatic wait_all_results();
    req.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // response side: random stalls, one long hold-off
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_armed;
    bit          jitter_on;
    int unsigned cyc;
    stall_left = 0;
    hold_left  = 0;
    hold_armed = 1'b1;
    jitter_on  = 1'b1;
    cyc        = 0;
    rsp.ready  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 64 == 0) jitter_on = ($urandom_range(0, 2) != 0);
      if (hold_armed && sent_count >= HoldAt) begin
        hold_armed = 1'b0;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (!calm && jitter_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t ERROR no beat for %0d cycles", $time, StallLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [ValueW-1:0] pool [PoolSize];
    logic [OpW-1:0]    op;
    logic [ValueW-1:0] value;
    int unsigned       add_pct;
    int unsigned       r;
    bit                gap_on;
    rst_ni       = 1'b0;
    req.valid    = 1'b0;
    req.op       = OP_ADD;
    req.value    = '0;
    sent_count   = 0;
    calm         = 1'b0;
    add_pct      = 50;
    gap_on       = 1'b1;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;
    pool[4] = $urandom;
    pool[5] = $urandom;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list
    send_request(OP_SEARCH, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000);
    send_request(OpNop, 32'hffff_ffff);
    // extremes and a duplicate at the head
    send_request(OP_ADD, 32'h8000_0000);
    send_request(OP_ADD, 32'h7fff_ffff);
    send_request(OP_ADD, 32'h0000_0000);
    send_request(OP_ADD, 32'hffff_ffff);
    send_request(OP_ADD, 32'h0000_0005);
    send_request(OP_ADD, 32'h0000_0005);
    send_request(OP_REMOVE, 32'h0000_0005);
    send_request(OP_SEARCH, 32'h0000_0005);
    send_request(OP_REMOVE, 32'h8000_0000);
    // fill, then overflow
    for (int k = 0; k < 12; k++) send_request(OP_ADD, $urandom);
    send_request(OP_ADD, 32'h1234_5678);
    send_request(OpNop, 32'h0000_0000);
    send_request(OP_REMOVE, 32'hffff_ffff);
    send_request(OP_SEARCH, 32'h7fff_ffff);

    for (int n = 0; n < int'(RandItems); n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       add_pct = 25;
          1:       add_pct = 50;
          default: add_pct = 85;
        endcase
        gap_on = ($urandom_range(0, 2) != 0);
      end
      if (n == int'(RandItems / 2)) wait_all_results();
      calm = (n >= int'(RandItems - CalmItems));
      if (n % 16 == 0) pool[$urandom_range(0, PoolSize - 1)] = $urandom;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = OpNop;
      end else if (r < add_pct) begin
        op = OP_ADD;
      end else if (r < add_pct + (100 - add_pct) / 2) begin
        op = OP_REMOVE;
      end else begin
        op = OP_SEARCH;
      end
      value = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, PoolSize - 1)] : $urandom;
      if (!calm && gap_on && $urandom_range(0, 4) == 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end
      send_request(op, value);
    end

    wait_all_results();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
